### rtl/core/bsw_pkg.sv
// shared constants and handshake structs for the b-spline weight block
`timescale 1ns / 1ps
`default_nettype none

package bsw_pkg;

   localparam int MAX_ORDER_DEF = 12;
   localparam int FRAC_BITS_DEF = 24;

   localparam int HO_W = 3;
   localparam logic [HO_W-1:0] HALF_ORDER_RST = 3'd2;
   localparam logic [HO_W-1:0] HALF_ORDER_MIN = 3'd2;

   // order of the first recursion pass, seeded from x
   localparam int SEED_ORDER = 3;

   typedef struct packed {
      logic valid;
      logic seed;
      logic fin;
   } bsw_issue_type;

   typedef struct packed {
      logic wr;
      logic done;
   } bsw_wb_type;

endpackage

`default_nettype wire

### rtl/core/bsw_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/bsw_step.sv
// pipelined recursion step: one spline entry raised by one order per cycle, unless hazard holds issue
`timescale 1ns / 1ps
`default_nettype none

module bsw_step import bsw_pkg::*; #(
   parameter int MAX_ORDER = MAX_ORDER_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_ORDER + 1),
   localparam int W_W = FRAC_BITS + 1,
   localparam int SL_W = FRAC_BITS + 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsw_issue_type        iss,
   input  wire logic [IDX_W-1:0]     iss_k,
   input  wire logic [IDX_W-1:0]     iss_n,
   input  wire logic [FRAC_BITS-1:0] x,
   input  wire logic [W_W-1:0]       rd_weight,
   output logic                      hazard,
   output bsw_wb_type                wb,
   output logic [IDX_W-1:0]          wb_addr,
   output logic [W_W-1:0]            wb_weight,
   output logic [SL_W-1:0]           wb_slope
);

   localparam int PA_W = FRAC_BITS + W_W;
   localparam int NUM_W = FRAC_BITS + IDX_W + 1;
   localparam int KA_W = NUM_W;
   localparam int NS_W = NUM_W + 1;
   localparam int M_W = NUM_W + IDX_W;
   localparam int H = NUM_W / 2;
   localparam int PL_W = H + M_W;
   localparam int PH_W = NUM_W - H + M_W;
   localparam int PR_W = NUM_W + M_W;
   localparam int TAB_N = 2 ** IDX_W;
   localparam logic [W_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PA_W-1:0] HALF_Q = PA_W'(1) << (FRAC_BITS - 1);
   localparam logic [M_W:0] POW_M = {1'b1, {M_W{1'b0}}};

   // reciprocal table, ceil(2^M_W / d): exact floor division for NUM_W-bit numerators
   logic [M_W-1:0] recip_tab [TAB_N];

   for (genvar g = 0; g < TAB_N; g++) begin : g_recip
      if (g < 2) begin : g_none
         assign recip_tab[g] = '0;
      end else begin : g_val
         localparam logic [M_W-1:0] RECIP = M_W'((POW_M + g - 1) / g);
         assign recip_tab[g] = RECIP;
      end
   end

   // stage 0: memory data arrives
   logic             s0_vld_ff;
   logic [IDX_W-1:0] s0_k_ff, s0_n_ff;
   logic             s0_seed_ff, s0_fin_ff;
   logic [W_W-1:0]   a_prev_ff;
   logic [W_W-1:0]   a_seed, a_sel, b_sel;
   logic             s0_top;

   // stage 1: products
   logic             s1_vld_ff;
   logic [IDX_W-1:0] s1_k_ff, s1_d_ff;
   logic             s1_fin_ff, s1_top_ff;
   logic [SL_W-1:0]  s1_sl_ff;
   logic [PA_W-1:0]  s1_pa_ff, s1_pb_ff;
   logic [KA_W-1:0]  s1_ka_ff, s1_nb_ff;
   logic [PA_W-1:0]  pa_in, pb_in;
   logic [KA_W-1:0]  ka_in, nb_in;
   logic [SL_W-1:0]  sl_in;
   logic [IDX_W-1:0] d_in;

   // stage 2: rounded numerator
   logic             s2_vld_ff;
   logic [IDX_W-1:0] s2_k_ff, s2_d_ff;
   logic             s2_fin_ff, s2_top_ff;
   logic [SL_W-1:0]  s2_sl_ff;
   logic [NUM_W-1:0] s2_num_ff;
   logic [PA_W-1:0]  ra_sum, rb_sum;
   logic [W_W-1:0]   ra, rb;
   logic signed [NS_W-1:0] num_s;
   logic [NUM_W-1:0] num_c, num_in;

   // stage 3: reciprocal partial products
   logic             s3_vld_ff;
   logic [IDX_W-1:0] s3_k_ff;
   logic             s3_fin_ff, s3_top_ff;
   logic [SL_W-1:0]  s3_sl_ff;
   logic [PL_W-1:0]  s3_pl_ff;
   logic [PH_W-1:0]  s3_ph_ff;
   logic [M_W-1:0]   recip;
   logic [PL_W-1:0]  pl_in;
   logic [PH_W-1:0]  ph_in;
   logic [PR_W-1:0]  prod;
   logic [NUM_W-1:0] quo;

   // stage 0 operand selection
   always_comb begin
      s0_top = (s0_k_ff == s0_n_ff);
      if (s0_k_ff == IDX_W'(0)) begin
         a_seed = W_W'(x);
      end else if (s0_k_ff == IDX_W'(1)) begin
         a_seed = ONE_Q - W_W'(x);
      end else begin
         a_seed = '0;
      end
      if (s0_top) begin
         a_sel = '0;
      end else if (s0_seed_ff) begin
         a_sel = a_seed;
      end else begin
         a_sel = rd_weight;
      end
      b_sel = (s0_k_ff == IDX_W'(0)) ? '0 : a_prev_ff;
      pa_in = PA_W'(x) * PA_W'(a_sel);
      pb_in = PA_W'(x) * PA_W'(b_sel);
      ka_in = KA_W'(s0_k_ff) * KA_W'(a_sel);
      nb_in = KA_W'(s0_n_ff - s0_k_ff) * KA_W'(b_sel);
      // difference of two values in [0,1] stays within [-1,1]
      sl_in = SL_W'(a_sel) - SL_W'(b_sel);
      d_in  = s0_n_ff - IDX_W'(1);
   end

   // stage 1 rounding and sum
   always_comb begin
      ra_sum = s1_pa_ff + HALF_Q;
      rb_sum = s1_pb_ff + HALF_Q;
      ra = ra_sum[PA_W-1:FRAC_BITS];
      rb = rb_sum[PA_W-1:FRAC_BITS];
      num_s = NS_W'(ra) + NS_W'(s1_ka_ff) + NS_W'(s1_nb_ff) - NS_W'(rb);
      num_c = num_s[NS_W-1] ? '0 : num_s[NUM_W-1:0];
      num_in = num_c + NUM_W'(s1_d_ff >> 1);
   end

   // stage 2 split reciprocal multiply
   always_comb begin
      recip = recip_tab[s2_d_ff];
      pl_in = PL_W'(s2_num_ff[H-1:0]) * PL_W'(recip);
      ph_in = PH_W'(s2_num_ff[NUM_W-1:H]) * PH_W'(recip);
   end

   // stage 3 combine, quotient, saturate
   always_comb begin
      prod = (PR_W'(s3_ph_ff) << H) + PR_W'(s3_pl_ff);
      quo  = prod[PR_W-1:M_W];
      wb_weight = (quo > NUM_W'(ONE_Q)) ? ONE_Q : quo[W_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= iss.valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_k_ff    <= iss_k;
      s0_n_ff    <= iss_n;
      s0_seed_ff <= iss.seed;
      s0_fin_ff  <= iss.fin;
      if (s0_vld_ff) begin
         a_prev_ff <= a_sel;
      end

      s1_k_ff   <= s0_k_ff;
      s1_d_ff   <= d_in;
      s1_fin_ff <= s0_fin_ff;
      s1_top_ff <= s0_top;
      s1_sl_ff  <= sl_in;
      s1_pa_ff  <= pa_in;
      s1_pb_ff  <= pb_in;
      s1_ka_ff  <= ka_in;
      s1_nb_ff  <= nb_in;

      s2_k_ff   <= s1_k_ff;
      s2_d_ff   <= s1_d_ff;
      s2_fin_ff <= s1_fin_ff;
      s2_top_ff <= s1_top_ff;
      s2_sl_ff  <= s1_sl_ff;
      s2_num_ff <= num_in;

      s3_k_ff   <= s2_k_ff;
      s3_fin_ff <= s2_fin_ff;
      s3_top_ff <= s2_top_ff;
      s3_sl_ff  <= s2_sl_ff;
      s3_pl_ff  <= pl_in;
      s3_ph_ff  <= ph_in;
   end

   // an entry still in flight from the previous pass must land before it is read again
   assign hazard = (s0_vld_ff && (s0_k_ff == iss_k)) ||
                   (s1_vld_ff && (s1_k_ff == iss_k)) ||
                   (s2_vld_ff && (s2_k_ff == iss_k)) ||
                   (s3_vld_ff && (s3_k_ff == iss_k));

   assign wb.wr    = s3_vld_ff;
   assign wb.done  = s3_vld_ff && s3_fin_ff && s3_top_ff;
   assign wb_addr  = s3_k_ff;
   assign wb_slope = s3_sl_ff;

endmodule

`default_nettype wire

### rtl/core/cardinal_bspline_weights_top.sv
// cardinal b-spline weights and slopes: sequencer, entry memory and result port
// the recursion streams one entry per cycle through the step pipeline, unless the hazard
// interlock holds issue until an entry of the previous pass has landed; the final pass drains
// through the pipeline before results are read out; each result takes one memory read, issued
// only after the previous read has loaded the result register; results are stalled by rsp_ready
// a new offset is taken once the last result read is issued; reset sets the order to 4
`timescale 1ns / 1ps
`default_nettype none

module cardinal_bspline_weights_top import bsw_pkg::*; #(
   parameter int MAX_ORDER = MAX_ORDER_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_ORDER + 1),
   localparam int W_W = FRAC_BITS + 1,
   localparam int SL_W = FRAC_BITS + 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [FRAC_BITS-1:0] req_frac_offset,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [IDX_W-1:0]          rsp_point_index,
   output logic [W_W-1:0]            rsp_weight,
   output logic signed [SL_W-1:0]    rsp_slope,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [HO_W-1:0]      csr_half_order
);

   localparam int MEM_W = W_W + SL_W;
   localparam int OW = IDX_W + 1;
   localparam logic [OW-1:0] TOP_ORDER = OW'((MAX_ORDER / 2) * 2);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CALC  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [HO_W-1:0]      half_order_ff;
   logic [IDX_W-1:0]     order_ff, order_in;
   logic [FRAC_BITS-1:0] x_ff;
   logic [IDX_W-1:0]     pass_n_ff, pass_n_in;
   logic [IDX_W-1:0]     iss_k_ff, iss_k_in;
   logic [IDX_W-1:0]     emit_k_ff, emit_k_in;
   logic                 pend_ff;
   logic [IDX_W-1:0]     pend_k_ff;
   logic                 rsp_valid_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic [W_W-1:0]       rsp_weight_ff;
   logic [SL_W-1:0]      rsp_slope_ff;
   logic                 rsp_last_ff;

   logic [HO_W-1:0]  h_eff;
   logic [OW-1:0]    p_raw;
   logic             req_xfer, emit_rd, hazard;
   bsw_issue_type    iss;
   bsw_wb_type       wb;
   logic [IDX_W-1:0] wb_addr, rd_addr;
   logic [W_W-1:0]   wb_weight;
   logic [SL_W-1:0]  wb_slope;
   logic [MEM_W-1:0] rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // effective order: clamp half order from below, then to the largest even order
   always_comb begin
      h_eff = (half_order_ff < HALF_ORDER_MIN) ? HALF_ORDER_MIN : half_order_ff;
      p_raw = OW'({h_eff, 1'b0});
      order_in = (p_raw > TOP_ORDER) ? TOP_ORDER[IDX_W-1:0] : p_raw[IDX_W-1:0];
   end

   assign iss.valid = (state_ff == ST_CALC) && !hazard;
   assign iss.seed  = (pass_n_ff == IDX_W'(SEED_ORDER));
   assign iss.fin   = (pass_n_ff == order_ff);

   assign emit_rd = (state_ff == ST_EMIT) && !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign rd_addr = (state_ff == ST_EMIT) ? emit_k_ff : iss_k_ff;

   always_comb begin
      state_in  = state_ff;
      pass_n_in = pass_n_ff;
      iss_k_in  = iss_k_ff;
      emit_k_in = emit_k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in  = ST_CALC;
               pass_n_in = IDX_W'(SEED_ORDER);
               iss_k_in  = '0;
            end
         end
         ST_CALC: begin
            if (iss.valid) begin
               if (iss_k_ff == pass_n_ff) begin
                  iss_k_in = '0;
                  if (iss.fin) begin
                     state_in = ST_DRAIN;
                  end else begin
                     pass_n_in = pass_n_ff + IDX_W'(1);
                  end
               end else begin
                  iss_k_in = iss_k_ff + IDX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (wb.done) begin
               state_in  = ST_EMIT;
               emit_k_in = '0;
            end
         end
         ST_EMIT: begin
            if (emit_rd) begin
               emit_k_in = emit_k_ff + IDX_W'(1);
               if (emit_k_ff == order_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         half_order_ff <= HALF_ORDER_RST;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            half_order_ff <= csr_half_order;
         end
         pend_ff <= emit_rd;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pass_n_ff <= pass_n_in;
      iss_k_ff  <= iss_k_in;
      emit_k_ff <= emit_k_in;
      pend_k_ff <= emit_k_ff;
      if (req_xfer) begin
         x_ff     <= req_frac_offset;
         order_ff <= order_in;
      end
      // result register loads the registered read data in the cycle that pend_ff marks
      if (pend_ff) begin
         rsp_index_ff  <= pend_k_ff;
         rsp_weight_ff <= rd_data[MEM_W-1:SL_W];
         rsp_slope_ff  <= rd_data[SL_W-1:0];
         rsp_last_ff   <= (pend_k_ff == order_ff);
      end
   end

   bsw_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MAX_ORDER + 1)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wb.wr),
      .wr_addr (wb_addr),
      .wr_data ({wb_weight, wb_slope}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bsw_step #(
      .MAX_ORDER (MAX_ORDER),
      .FRAC_BITS (FRAC_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .iss       (iss),
      .iss_k     (iss_k_ff),
      .iss_n     (pass_n_ff),
      .x         (x_ff),
      .rd_weight (rd_data[MEM_W-1:SL_W]),
      .hazard    (hazard),
      .wb        (wb),
      .wb_addr   (wb_addr),
      .wb_weight (wb_weight),
      .wb_slope  (wb_slope)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_weight      = rsp_weight_ff;
   assign rsp_slope       = rsp_slope_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

### tb/sv/cardinal_bspline_weights_checker.sv
// checker for the b-spline weight block: predicts every weight and slope and compares results
`timescale 1ns / 1ps

module cardinal_bspline_weights_checker import bsw_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [FRAC_BITS_DEF-1:0]     req_frac_offset,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [3:0]                   rsp_point_index,
   input  logic [FRAC_BITS_DEF:0]       rsp_weight,
   input  logic signed [FRAC_BITS_DEF+1:0] rsp_slope,
   input  logic                         rsp_last,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [HO_W-1:0]              csr_half_order,
   output int                           fail_count,
   output int                           pending
);

   localparam int ORD = MAX_ORDER_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int W_W = FB + 1;
   localparam int SL_W = FB + 2;
   localparam int TOP_ORDER = ORD & ~1;
   localparam longint ONE_Q = longint'(1) << FB;
   localparam longint HALF_Q = longint'(1) << (FB - 1);
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [3:0]             index;
      logic [W_W-1:0]         weight;
      logic signed [SL_W-1:0] slope;
      logic                   last;
   } point_result_type;

   point_result_type expected_points [$];
   logic [HO_W-1:0] half_order_q;
   longint basis [0:ORD];
   longint next_basis [0:ORD];

   initial begin
      fail_count = 0;
      pending = 0;
      half_order_q = HALF_ORDER_RST;
   end

   task automatic report_mismatch(input string field, input longint got, input longint want);
      if (fail_count < PRINT_LIMIT)
         $display("%0t: %s got %0d want %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   function automatic longint scaled_by_x(input longint x, input longint v);
      return (x * v + HALF_Q) >>> FB;
   endfunction

   // one step of the triangular recursion, order n-1 to order n
   task automatic raise_basis(input longint x, input int n);
      longint a, b, num, q, d;
      d = n - 1;
      for (int k = 0; k <= n; k++) begin
         a = (k < n) ? basis[k] : 0;
         b = (k > 0) ? basis[k-1] : 0;
         num = scaled_by_x(x, a) + k * a + (n - k) * b - scaled_by_x(x, b);
         if (num < 0)
            num = 0;
         q = (num + d / 2) / d;
         if (q > ONE_Q)
            q = ONE_Q;
         next_basis[k] = q;
      end
      for (int k = 0; k <= n; k++)
         basis[k] = next_basis[k];
   endtask

   task automatic predict_points(input logic [FB-1:0] offset);
      int h, p;
      longint xs, s, cur, prev;
      longint slopes [0:ORD];
      point_result_type item;
      h = half_order_q;
      if (h < HALF_ORDER_MIN)
         h = HALF_ORDER_MIN;
      p = 2 * h;
      if (p > TOP_ORDER)
         p = TOP_ORDER;
      for (int k = 0; k <= ORD; k++)
         basis[k] = 0;
      xs = offset;
      basis[0] = xs;
      basis[1] = ONE_Q - xs;
      for (int n = SEED_ORDER; n < p; n++)
         raise_basis(xs, n);
      // slope comes from the order p-1 values
      for (int k = 0; k <= p; k++) begin
         cur = (k < p) ? basis[k] : 0;
         prev = (k > 0) ? basis[k-1] : 0;
         s = cur - prev;
         if (s > ONE_Q)
            s = ONE_Q;
         if (s < -ONE_Q)
            s = -ONE_Q;
         slopes[k] = s;
      end
      raise_basis(xs, p);
      for (int k = 0; k <= p; k++) begin
         item.index = 4'(k);
         item.weight = W_W'(basis[k]);
         item.slope = SL_W'(slopes[k]);
         item.last = (k == p);
         expected_points.insert(expected_points.size(), item);
      end
   endtask

   always @(posedge clock) begin
      point_result_type want;
      if (reset) begin
         half_order_q = HALF_ORDER_RST;
         expected_points.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("result with nothing expected, index", rsp_point_index, -1);
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_index !== want.index)
                  report_mismatch("point_index", rsp_point_index, want.index);
               if (rsp_weight !== want.weight)
                  report_mismatch("weight", rsp_weight, want.weight);
               if (rsp_slope !== want.slope)
                  report_mismatch("slope", rsp_slope, want.slope);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if (csr_valid && csr_ready)
            half_order_q = csr_half_order;
         if (req_valid && req_ready)
            predict_points(req_frac_offset);
      end
      pending <= expected_points.size();
   end

endmodule

### tb/sv/cardinal_bspline_weights_top_tb.sv
// testbench top for the b-spline weight block: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module cardinal_bspline_weights_top_tb;
   import bsw_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int ITEMS_PER_PHASE = 23;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [FB-1:0] req_frac_offset = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_point_index;
   logic [FB:0] rsp_weight;
   logic signed [FB+1:0] rsp_slope;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [HO_W-1:0] csr_half_order = HALF_ORDER_RST;
   int fail_count;
   int pending;
   int burst_left = 1;

   cardinal_bspline_weights_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_frac_offset(req_frac_offset),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_point_index(rsp_point_index),
      .rsp_weight(rsp_weight),
      .rsp_slope(rsp_slope),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_half_order(csr_half_order)
   );

   cardinal_bspline_weights_checker weight_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_frac_offset(req_frac_offset),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_point_index(rsp_point_index),
      .rsp_weight(rsp_weight),
      .rsp_slope(rsp_slope),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_half_order(csr_half_order),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // offer one offset and wait for its transfer; bursts end in a random gap, which may be zero
   task automatic offer_offset(input logic [FB-1:0] x);
      int gap;
      req_valid <= 1'b1;
      req_frac_offset <= x;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // register writes only once every expected result is out
   task automatic write_half_order(input logic [HO_W-1:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      csr_valid <= 1'b1;
      csr_half_order <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall modes, plus one long hold-off while input keeps coming
   initial begin
      int mode, dwell, hold, seen;
      bit held;
      mode = 0;
      dwell = 0;
      hold = 0;
      seen = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            seen++;
         if (seen == HOLD_AFTER && !held) begin
            held = 1;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            if (dwell == 0) begin
               mode = $urandom_range(0, 3);
               dwell = $urandom_range(20, 80);
            end
            dwell--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // watchdog: too long without any transfer
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [HO_W-1:0] phase_orders [13];
      logic [FB-1:0] x;
      phase_orders = '{3'd3, 3'd4, 3'd5, 3'd2, 3'd6, 3'd7, 3'd0, 3'd1,
                       3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: offset extremes at the reset order, then too small, too large, max and too small again
      offer_offset('0);
      offer_offset(24'h000001);
      offer_offset(24'hFFFFFF);
      offer_offset(24'h800000);
      write_half_order(3'd0);
      offer_offset('0);
      offer_offset(24'hFFFFFF);
      write_half_order(3'd7);
      offer_offset('0);
      offer_offset(24'hFFFFFF);
      offer_offset(24'h800000);
      write_half_order(3'd6);
      offer_offset(24'h000001);
      offer_offset(24'hFFFFFE);
      write_half_order(3'd1);
      offer_offset(24'hAAAAAA);
      offer_offset(24'h555555);

      foreach (phase_orders[i]) begin
         write_half_order(phase_orders[i]);
         repeat (ITEMS_PER_PHASE) begin
            case ($urandom_range(0, 9))
               0: x = '0;
               1: x = 24'hFFFFFF;
               2: x = FB'($urandom_range(0, 255));
               3: x = 24'hFFFFFF - FB'($urandom_range(0, 255));
               default: x = FB'($urandom);
            endcase
            offer_offset(x);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
rtl/core/bsw_pkg.sv
rtl/core/bsw_ram.sv
rtl/core/bsw_step.sv
rtl/core/cardinal_bspline_weights_top.sv
tb/sv/cardinal_bspline_weights_checker.sv
tb/sv/cardinal_bspline_weights_top_tb.sv
